// ----- hdl/sgr_pkg.sv -----
// shared types, constants and the quarter-wave sine polynomial
// for the sine generator with linear amplitude ramp; no dependencies
package sgr_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	localparam int AMP_BITS     = 32;
	localparam int SIN_BITS     = 31;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_BITS     = 32;

	localparam logic [AMP_BITS-1:0] AMP_START_RST = 32'h4000_0000;
	localparam logic [SIN_BITS-1:0] SIN_ONE       = 31'h4000_0000;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned SIN_A1  = 64'd1686629713;
	localparam longint unsigned SIN_A3  = 64'd693598668;
	localparam longint unsigned SIN_A5  = 64'd85569306;
	localparam longint unsigned SIN_A7  = 64'd5026995;
	localparam longint unsigned SIN_A9  = 64'd172272;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_AMP_START  = 2'd1,
		CFG_AMP_STEP   = 2'd2
	} cfg_idx_t;

	// one item after the sine lookup
	typedef struct packed {
		logic [SIN_BITS-1:0] sin;
		logic                neg;
		logic [AMP_BITS-1:0] amp;
	} lane_s1_t;

	// sin(pi/2 * x), x in q30 over [0, 1], odd horner polynomial, clamped to 1.0
	// only evaluated at elaboration to fill the rom
	function automatic logic [SIN_BITS-1:0] quarter_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		x2 = (x * x) >> 30;
		t  = SIN_A9;
		t  = SIN_A7 - ((x2 * t) >> 30);
		t  = SIN_A5 - ((x2 * t) >> 30);
		t  = SIN_A3 - ((x2 * t) >> 30);
		t  = SIN_A1 - ((x2 * t) >> 30);
		t  = (x * t) >> 30;
		if (t > Q30_ONE) begin
			t = Q30_ONE;
		end
		return t[SIN_BITS-1:0];
	endfunction

endpackage

// ----- hdl/sine_generator_linear_amplitude_ramp_top.sv -----
// top level of the sine generator with linear amplitude ramp
// depends on sgr_pkg, sgr_accum, sgr_sine_lut, sgr_scale
//
//  channel | signals                                  | dir | beat when
//  in      | in_valid, in_stall, restart              | in  | in_valid & !in_stall
//  out     | out_valid, out_stall, left/right_sample  | out | out_valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in  | cfg_valid & cfg_ready
//
// one item per cycle unless out_stall holds the pipeline; after its input beat a sample
// passes the sine rom read, the multiply, and round and saturate into the output register
// reset clears the stage valids, phase accumulator and step registers, amplitude to amp_start
// a stage moves when the one after it is empty or moving, so out_stall reaches
// in_stall only when all three stages hold an item; cfg_ready is always high
module sine_generator_linear_amplitude_ramp_top #(
	parameter int PHASE_BITS      = sgr_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = sgr_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = sgr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]    left_sample,
	output logic signed [SAMPLE_BITS-1:0]    right_sample,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sgr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sgr_pkg::CFG_BITS-1:0]     cfg_data
);
	import sgr_pkg::*;

	logic                       v_s1;
	logic                       v_s2;
	logic                       out_valid_q;
	logic                       adv_out;
	logic                       adv_s2;
	logic                       adv_s1;
	logic                       take;
	logic [TABLE_ADDR_BITS-2:0] lut_idx;
	logic                       neg;
	logic [AMP_BITS-1:0]        amp;
	lane_s1_t                   lane_s1;
	logic [SAMPLE_BITS-1:0]     sample_q;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign take     = in_valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	sgr_accum #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.restart   (restart),
		.lut_idx   (lut_idx),
		.neg       (neg),
		.amp       (amp)
	);

	sgr_sine_lut #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_lut (
		.clk     (clk),
		.en      (take),
		.lut_idx (lut_idx),
		.neg     (neg),
		.amp     (amp),
		.lane_s1 (lane_s1)
	);

	sgr_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk      (clk),
		.en_s2    (adv_s2 && v_s1),
		.en_out   (adv_out && v_s2),
		.lane_s1  (lane_s1),
		.sample_q (sample_q)
	);

	assign out_valid    = out_valid_q;
	assign left_sample  = sample_q;
	assign right_sample = sample_q;

	// input only backs up when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// an accepted beat always lands in the first stage
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat lost before stage one");

	// a held output sample cannot be overwritten by the stage behind it
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && v_s2) |=> (out_valid_q && v_s2))
		else $error("stage two item dropped while output held");

endmodule

// ----- hdl/sgr_accum.sv -----
// configuration registers plus phase and amplitude accumulators
// depends on sgr_pkg
module sgr_accum #(
	parameter int PHASE_BITS      = sgr_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = sgr_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [sgr_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               take,
	input  logic                               restart,
	output logic [TABLE_ADDR_BITS-2:0]         lut_idx,
	output logic                               neg,
	output logic [sgr_pkg::AMP_BITS-1:0]       amp
);
	import sgr_pkg::*;

	localparam int QTR_BITS = TABLE_ADDR_BITS - 2;

	logic [CFG_BITS-1:0]        phase_step_q;
	logic [AMP_BITS-1:0]        amp_start_q;
	logic [CFG_BITS-1:0]        amp_step_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic [AMP_BITS-1:0]        amp_q;
	logic [PHASE_BITS-1:0]      phase_eff;
	logic [AMP_BITS-1:0]        amp_eff;
	logic [TABLE_ADDR_BITS-1:0] addr;
	logic [QTR_BITS-1:0]        pos;
	logic signed [AMP_BITS+1:0] amp_sum;
	logic [AMP_BITS-1:0]        amp_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			amp_start_q  <= AMP_START_RST;
			amp_step_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PHASE_STEP: phase_step_q <= cfg_data;
				CFG_AMP_START:  amp_start_q  <= cfg_data;
				CFG_AMP_STEP:   amp_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// restart applies before the sample of the same beat
	assign phase_eff = restart ? '0 : phase_q;
	assign amp_eff   = restart ? amp_start_q : amp_q;

	assign addr = phase_eff[PHASE_BITS-1 -: TABLE_ADDR_BITS];
	assign pos  = addr[QTR_BITS-1:0];
	assign neg  = addr[TABLE_ADDR_BITS-1];
	assign amp  = amp_eff;

	// odd quadrants run the quarter wave backwards, index reaches the full quarter
	always_comb begin
		if (addr[TABLE_ADDR_BITS-2]) begin
			lut_idx = (TABLE_ADDR_BITS-1)'(1 << QTR_BITS) - {1'b0, pos};
		end else begin
			lut_idx = {1'b0, pos};
		end
	end

	assign amp_sum = $signed({2'b00, amp_eff}) +
		$signed({{2{amp_step_q[CFG_BITS-1]}}, amp_step_q});

	always_comb begin
		if (amp_sum[AMP_BITS+1]) begin
			amp_next = '0;
		end else if (amp_sum[AMP_BITS]) begin
			amp_next = '1;
		end else begin
			amp_next = amp_sum[AMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			amp_q   <= AMP_START_RST;
		end else if (take) begin
			phase_q <= phase_eff + PHASE_BITS'(phase_step_q);
			amp_q   <= amp_next;
		end
	end

endmodule

// ----- hdl/sgr_sine_lut.sv -----
// quarter-wave sine rom filled at elaboration, registered lookup
// depends on sgr_pkg
module sgr_sine_lut #(
	parameter int TABLE_ADDR_BITS = sgr_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [TABLE_ADDR_BITS-2:0]   lut_idx,
	input  logic                         neg,
	input  logic [sgr_pkg::AMP_BITS-1:0] amp,
	output sgr_pkg::lane_s1_t            lane_s1
);
	import sgr_pkg::*;

	localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
	localparam int QTR      = 1 << QTR_BITS;

	typedef logic [QTR-1:0][SIN_BITS-1:0] rom_t;

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < QTR; i++) begin
			r[i] = quarter_sine(longint'(i) << (32 - TABLE_ADDR_BITS));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			// top index bit set only at the quarter point, where the sine is 1.0
			lane_s1.sin <= lut_idx[QTR_BITS] ? SIN_ONE : SINE_ROM[lut_idx[QTR_BITS-1:0]];
			lane_s1.neg <= neg;
			lane_s1.amp <= amp;
		end
	end

endmodule

// ----- hdl/sgr_scale.sv -----
// amplitude multiply, then rounding, sign and saturation to the sample width
// depends on sgr_pkg
module sgr_scale #(
	parameter int SAMPLE_BITS = sgr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en_s2,
	input  logic                     en_out,
	input  sgr_pkg::lane_s1_t        lane_s1,
	output logic [SAMPLE_BITS-1:0]   sample_q
);
	import sgr_pkg::*;

	localparam int PROD_BITS = SIN_BITS + AMP_BITS;
	localparam int SHIFT     = 61 - SAMPLE_BITS;
	localparam int RND_BITS  = PROD_BITS - SHIFT;
	localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (SHIFT - 1);
	localparam logic [RND_BITS-1:0]  LIM  = RND_BITS'(1) << (SAMPLE_BITS - 1);

	logic [PROD_BITS-1:0] prod_s2;
	logic                 neg_s2;
	logic [PROD_BITS-1:0] rsum;
	logic [RND_BITS-1:0]  rounded;
	logic [RND_BITS-1:0]  mag_c;
	logic [RND_BITS-1:0]  res;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= PROD_BITS'(lane_s1.sin) * PROD_BITS'(lane_s1.amp);
			neg_s2  <= lane_s1.neg;
		end
	end

	// round half up on the magnitude, sign applied after clamping
	assign rsum    = prod_s2 + HALF;
	assign rounded = rsum[PROD_BITS-1:SHIFT];

	always_comb begin
		if (neg_s2) begin
			mag_c = (rounded > LIM) ? LIM : rounded;
			res   = RND_BITS'(0) - mag_c;
		end else begin
			mag_c = (rounded > LIM - RND_BITS'(1)) ? LIM - RND_BITS'(1) : rounded;
			res   = mag_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sample_q <= res[SAMPLE_BITS-1:0];
		end
	end

endmodule

// ----- dv/sine_generator_linear_amplitude_ramp_top_tb.sv -----
// self-checking bench for the sine generator with linear amplitude ramp
// depends on sgr_pkg and sine_generator_linear_amplitude_ramp_top; predicts every
// stereo sample from its own nco and ramp model and compares it in order
module sine_generator_linear_amplitude_ramp_top_tb;
	import sgr_pkg::*;

	localparam int SMP_W        = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 250;
	localparam int PIPE_CYCLES  = 8;
	localparam int MAX_PRINTS   = 30;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;

	// quarter-wave polynomial coefficients, q30
	localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
	localparam longint unsigned K1 = 64'd1686629713;
	localparam longint unsigned K3 = 64'd693598668;
	localparam longint unsigned K5 = 64'd85569306;
	localparam longint unsigned K7 = 64'd5026995;
	localparam longint unsigned K9 = 64'd172272;

	typedef struct {
		bit          restart;
		int unsigned gap;
	} tick_t;

	typedef struct packed {
		logic [SMP_W-1:0] left;
		logic [SMP_W-1:0] right;
	} stereo_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic                    restart      = 1'b0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic signed [SMP_W-1:0] left_sample;
	logic signed [SMP_W-1:0] right_sample;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic [CFG_BITS-1:0]     cfg_data     = '0;

	// predictor state and register shadows
	logic [31:0]        tone_step  = '0;
	logic [31:0]        ramp_start = 32'h4000_0000;
	logic signed [31:0] ramp_inc   = '0;
	logic [31:0]        nco_phase  = '0;
	logic [31:0]        ramp_amp   = 32'h4000_0000;

	tick_t   tick_q[$];
	stereo_t sample_q[$];

	bit          idle_on     = 1'b0;
	logic        rx_hold     = 1'b0;
	int unsigned tx_gap      = 0;
	int unsigned rx_wait     = 0;
	int unsigned err_cnt     = 0;
	int unsigned sent_cnt    = 0;
	int unsigned checked_cnt = 0;
	int unsigned restart_cnt = 0;
	int unsigned cfg_cnt     = 0;
	int unsigned cycle_cnt   = 0;

	sine_generator_linear_amplitude_ramp_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS) begin
			$display("mismatch %s at sample %0d: got %h want %h", what, checked_cnt, got, want);
		end
	endtask

	// sin(pi/2 * x) in q30, x in q30 over [0, 1]
	function automatic longint unsigned sine_q30(input longint unsigned x);
		longint unsigned sq;
		longint unsigned acc;
		sq  = (x * x) >> 30;
		acc = K9;
		acc = K7 - ((sq * acc) >> 30);
		acc = K5 - ((sq * acc) >> 30);
		acc = K3 - ((sq * acc) >> 30);
		acc = K1 - ((sq * acc) >> 30);
		acc = (x * acc) >> 30;
		if (acc > UNIT_Q30) begin
			acc = UNIT_Q30;
		end
		return acc;
	endfunction

	// one tick: on restart reset phase and ramp, emit sine(phase) * amplitude, then step phase and ramp
	task automatic advance_tone(input logic rst);
		longint unsigned x;
		longint unsigned prod;
		longint unsigned mag;
		longint          nxt_amp;
		logic [SMP_W-1:0] smp;
		if (rst) begin
			nco_phase = '0;
			ramp_amp  = ramp_start;
		end
		x = {34'd0, nco_phase[29:22], 22'd0};
		if (nco_phase[30]) begin
			x = UNIT_Q30 - x;
		end
		prod = sine_q30(x) * {32'd0, ramp_amp};
		// round half up on the magnitude, q3.60 down to q1.15
		mag = (prod + (64'd1 << 44)) >> 45;
		if (nco_phase[31]) begin
			if (mag > 64'd32768) begin
				mag = 64'd32768;
			end
			smp = -mag[SMP_W-1:0];
		end else begin
			if (mag > 64'd32767) begin
				mag = 64'd32767;
			end
			smp = mag[SMP_W-1:0];
		end
		sample_q.push_back('{left: smp, right: smp});
		nco_phase = nco_phase + tone_step;
		nxt_amp = longint'({32'd0, ramp_amp}) + longint'(ramp_inc);
		if (nxt_amp < 0) begin
			nxt_amp = 0;
		end
		if (nxt_amp > 64'sh0_FFFF_FFFF) begin
			nxt_amp = 64'sh0_FFFF_FFFF;
		end
		ramp_amp = nxt_amp[31:0];
	endtask

	// sender: one beat per queued tick, after that tick's gap
	always @(posedge clk or negedge arst_n) begin : drv
		logic  nxt_valid;
		tick_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart  <= 1'b0;
			tx_gap = 0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				advance_tone(restart);
				sent_cnt++;
				if (restart) begin
					restart_cnt++;
				end
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && tick_q.size() > 0) begin
				if (tx_gap < tick_q[0].gap) begin
					tx_gap++;
				end else begin
					cur = tick_q.pop_front();
					restart <= cur.restart;
					nxt_valid = 1'b1;
					tx_gap = 0;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// receiver: compare each beat, then stall for a drawn number of cycles when idle gaps are on, and while rx_hold is set
	always @(posedge clk or negedge arst_n) begin : mon
		stereo_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sample_q.size() == 0) begin
					flag_mismatch("unexpected sample", 32'(left_sample), 32'hx);
				end else begin
					want = sample_q.pop_front();
					if (left_sample !== want.left) begin
						flag_mismatch("left_sample", 32'(left_sample), 32'(want.left));
					end
					if (right_sample !== want.right) begin
						flag_mismatch("right_sample", 32'(right_sample), 32'(want.right));
					end
				end
				checked_cnt++;
				rx_wait = idle_on ? $urandom_range(0, 6) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= rx_hold || (rx_wait > 0);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_PHASE_STEP: tone_step  = val;
			CFG_AMP_START:  ramp_start = val;
			CFG_AMP_STEP:   ramp_inc   = val;
			default: ;
		endcase
		cfg_cnt++;
		cfg_valid <= 1'b0;
	endtask

	task automatic push_tick(input bit rst, input int unsigned gap);
		tick_q.push_back('{restart: rst, gap: gap});
	endtask

	task automatic queue_ticks(input int n, input bit gaps);
		for (int i = 0; i < n; i++) begin
			push_tick($urandom_range(0, 15) == 0, gaps ? $urandom_range(0, 6) : 0);
		end
	endtask

	// wait until every queued tick went out and every sample came back
	task automatic drain();
		do @(negedge clk); while (tick_q.size() > 0 || in_valid || sample_q.size() > 0);
	endtask

	initial begin : stim
		logic [31:0] v;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// reset values: zero step, unit amplitude
		push_tick(1'b0, 0);
		push_tick(1'b1, 2);
		drain();

		// quarter-turn steps, full-scale amplitude ramping down to the floor
		write_reg(CFG_PHASE_STEP, 32'h4000_0000);
		write_reg(CFG_AMP_START, 32'hFFFF_FFFF);
		write_reg(CFG_AMP_STEP, 32'h8000_0000);
		write_reg(CFG_SPARE_IDX, $urandom);
		@(negedge clk);
		push_tick(1'b1, 0);
		for (int i = 0; i < 5; i++) push_tick(1'b0, $urandom_range(0, 6));
		drain();

		// ramp up into the ceiling, negative peak saturates
		write_reg(CFG_AMP_START, 32'hC000_0000);
		write_reg(CFG_AMP_STEP, 32'h7FFF_FFFF);
		@(negedge clk);
		push_tick(1'b1, 0);
		for (int i = 0; i < 5; i++) push_tick(1'b0, 0);
		drain();

		// largest phase step walks backwards through the last quadrant
		write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_AMP_START, 32'h2000_0000);
		write_reg(CFG_AMP_STEP, 32'h0000_0000);
		@(negedge clk);
		push_tick(1'b1, 0);
		for (int i = 0; i < 4; i++) push_tick(1'b0, 1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 2))
				0: v = $urandom;
				1: v = $urandom_range(0, 32'h0100_0000);
				default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
			endcase
			write_reg(CFG_PHASE_STEP, v);
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = 32'h0000_0000;
				2: v = 32'hFFFF_FFFF;
				default: v = $urandom_range(32'h2000_0000, 32'h6000_0000);
			endcase
			write_reg(CFG_AMP_START, v);
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = 32'h0000_0000;
				default: begin
					v = $urandom_range(0, 32'h0040_0000);
					if ($urandom_range(0, 1) != 0) v = -v;
				end
			endcase
			write_reg(CFG_AMP_STEP, v);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_SPARE_IDX, $urandom);
			end
			@(negedge clk);
			if (ph == 4) begin
				// receiver holds off long enough for the pipeline to back up
				idle_on = 1'b0;
				queue_ticks(143, 1'b0);
				fork
					begin
						rx_hold <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end else begin
				idle_on = (ph != 0) && ($urandom_range(0, 2) != 0);
				queue_ticks(143, idle_on);
			end
			drain();
		end

		repeat (PIPE_CYCLES) @(posedge clk);
		if (sample_q.size() != 0) begin
			flag_mismatch("samples never delivered", sample_q.size(), 0);
		end
		$display("run covered %0d ticks (%0d restarts), %0d samples checked, %0d register writes",
			sent_cnt, restart_cnt, checked_cnt, cfg_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/sgr_pkg.sv
hdl/sgr_accum.sv
hdl/sgr_sine_lut.sv
hdl/sgr_scale.sv
hdl/sine_generator_linear_amplitude_ramp_top.sv
dv/sine_generator_linear_amplitude_ramp_top_tb.sv
